>>> rtl/sq_pkg.sv
`default_nettype none

package sq_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int DATA_W = 32;
	localparam int CMD_W = 2;
	localparam int STATUS_W = 2;
	localparam int POS_W = 5;

	localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FIND = 2'd2;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

endpackage

`default_nettype wire

>>> rtl/sq_ram.sv
`default_nettype none

module sq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/searchable_queue_core.sv
`default_nettype none

// Enqueue writes at the tail and dequeue reads the head; find scans from the head and
// reports the match's position, and remove also moves each entry behind the match forward
// by one slot. One command is in work at a time and the scan reads one entry per cycle.
// Reset clears head, occupancy and handshake state; the memory is not cleared.
module searchable_queue_core #(
	parameter int CAPACITY = sq_pkg::CAPACITY_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [sq_pkg::CMD_W-1:0]            cmd,
	input  wire logic signed [sq_pkg::DATA_W-1:0]    value,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [sq_pkg::STATUS_W-1:0]              status,
	output logic [sq_pkg::POS_W-1:0]                 position,
	output logic signed [sq_pkg::DATA_W-1:0]         data
);

	import sq_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(CAPACITY - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEQ = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_FIN = 3'd4;

	logic [2:0] state_q;
	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] occ_q;
	logic [CMD_W-1:0] cmd_q;
	logic [DATA_W-1:0] value_q;

	logic [CNT_W-1:0] iss_q;
	logic [IDX_W-1:0] iss_slot_q;
	logic cmp_valid_s1;
	logic [CNT_W-1:0] cmp_off_s1;
	logic [IDX_W-1:0] cmp_slot_s1;
	logic [CNT_W-1:0] w_off_q;
	logic [IDX_W-1:0] w_slot_q;

	logic [STATUS_W-1:0] res_status_q;
	logic [POS_W-1:0] res_pos_q;
	logic [DATA_W-1:0] res_data_q;

	logic out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [POS_W-1:0] out_pos_q;
	logic [DATA_W-1:0] out_data_q;

	logic in_xfer;
	logic ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic [IDX_W-1:0] ram_raddr;
	logic [DATA_W-1:0] ram_rdata;
	logic [CNT_W:0] tail_sum;
	logic [IDX_W-1:0] tail_slot;
	logic [IDX_W-1:0] head_next;
	logic [IDX_W-1:0] iss_slot_next;
	logic [IDX_W-1:0] w_slot_next;
	logic [CNT_W:0] pos_full;
	logic cmp_hit;
	logic is_full;
	logic is_empty;

	function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] s);
		return (s == LAST_SLOT) ? '0 : s + 1'b1;
	endfunction

	assign in_ready = (state_q == S_IDLE);
	assign in_xfer = in_valid && in_ready;
	assign is_full = (occ_q == FULL_CNT);
	assign is_empty = (occ_q == '0);

	// Head plus occupancy stays below twice the capacity, so one subtract wraps it.
	assign tail_sum = (CNT_W + 1)'(head_q) + (CNT_W + 1)'(occ_q);
	assign tail_slot = (tail_sum >= (CNT_W + 1)'(CAPACITY)) ?
		IDX_W'(tail_sum - (CNT_W + 1)'(CAPACITY)) : IDX_W'(tail_sum);
	assign head_next = slot_inc(head_q);
	assign iss_slot_next = slot_inc(iss_slot_q);
	assign w_slot_next = slot_inc(w_slot_q);

	assign cmp_hit = cmp_valid_s1 && (ram_rdata == value_q);
	assign pos_full = (CNT_W + 1)'(cmp_off_s1) + 1'b1;

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = w_slot_q;
		ram_wdata = ram_rdata;
		ram_raddr = iss_slot_q;
		if (state_q == S_IDLE) begin
			ram_raddr = head_q;
			ram_waddr = tail_slot;
			ram_wdata = value;
			ram_we = in_xfer && (cmd == CMD_ENQUEUE) && !is_full;
		end else if (state_q == S_SHIFT) begin
			ram_we = ((CNT_W + 1)'(w_off_q) + 1'b1) < (CNT_W + 1)'(occ_q);
		end
	end

	sq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			occ_q <= '0;
			cmp_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// In S_FIN the output register is reloaded whenever it is taken.
			if (out_valid_q && out_ready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						cmd_q <= cmd;
						value_q <= value;
						res_pos_q <= '0;
						res_data_q <= '0;
						iss_q <= CNT_W'(1);
						iss_slot_q <= head_next;
						cmp_valid_s1 <= 1'b1;
						cmp_off_s1 <= '0;
						cmp_slot_s1 <= head_q;
						if (cmd == CMD_ENQUEUE) begin
							if (is_full) begin
								res_status_q <= ST_FULL;
							end else begin
								res_status_q <= ST_OK;
								occ_q <= occ_q + 1'b1;
							end
							state_q <= S_FIN;
						end else if (is_empty) begin
							res_status_q <= ST_EMPTY;
							state_q <= S_FIN;
						end else if (cmd == CMD_DEQUEUE) begin
							res_status_q <= ST_OK;
							head_q <= head_next;
							occ_q <= occ_q - 1'b1;
							state_q <= S_DEQ;
						end else begin
							res_status_q <= ST_OK;
							state_q <= S_SCAN;
						end
					end
				end
				S_DEQ: begin
					res_data_q <= ram_rdata;
					state_q <= S_FIN;
				end
				S_SCAN: begin
					// One read in flight: the memory output belongs to cmp_off_s1.
					cmp_valid_s1 <= iss_q < occ_q;
					cmp_off_s1 <= iss_q;
					cmp_slot_s1 <= iss_slot_q;
					iss_q <= iss_q + 1'b1;
					iss_slot_q <= iss_slot_next;
					if (cmp_hit) begin
						res_pos_q <= POS_W'(pos_full);
						if (cmd_q == CMD_REMOVE) begin
							w_off_q <= cmp_off_s1;
							w_slot_q <= cmp_slot_s1;
							state_q <= S_SHIFT;
						end else begin
							state_q <= S_FIN;
						end
					end else if (!cmp_valid_s1 || pos_full >= (CNT_W + 1)'(occ_q)) begin
						res_status_q <= ST_NOT_FOUND;
						state_q <= S_FIN;
					end
				end
				S_SHIFT: begin
					// The read of the next entry was issued in the cycle before its write-back.
					iss_slot_q <= iss_slot_next;
					if (ram_we) begin
						w_off_q <= w_off_q + 1'b1;
						w_slot_q <= w_slot_next;
					end else begin
						occ_q <= occ_q - 1'b1;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_status_q <= res_status_q;
						out_pos_q <= res_pos_q;
						out_data_q <= res_data_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status = out_status_q;
	assign position = out_pos_q;
	assign data = out_data_q;

endmodule

`default_nettype wire
